// ===== design/skeq_pkg.sv =====
// Shared types and constants for the superkmer extend and query core.
package skeq_pkg;

    localparam int COMPACTED_LEN = 20;
    localparam int STORE_BYTES   = 16;

    localparam int NUC_CAP   = 4 * STORE_BYTES;
    localparam int STORE_W   = 8 * STORE_BYTES;
    localparam int KMER_W    = 2 * COMPACTED_LEN;
    localparam int OVL_W     = KMER_W - 2;
    localparam int EXT_W     = STORE_W + KMER_W;
    localparam int NEWP_W    = $clog2(COMPACTED_LEN + 32) + 1;
    localparam int SHIFT_W   = NEWP_W + 1;

    localparam int FUNC_W    = 2;
    localparam int KMER_IN_W = 40;
    localparam int MPOS_W    = 5;
    localparam int CNT_W     = 5;
    localparam int IDX_W     = 32;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 40;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_START  = 2'd0,
        FUNC_EXTEND = 2'd1,
        FUNC_QUERY  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_EXEC,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic exec;
    } t_cmd;

endpackage

// ===== design/skeq_ctrl.sv =====
// Controller state machine that sequences one item through the datapath.
module skeq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output skeq_pkg::t_cmd o_cmd
);

    skeq_pkg::t_state r_state;
    skeq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skeq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        o_cmd      = '0;
        case (r_state)
            skeq_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = skeq_pkg::ST_PREP;
                end
            end
            skeq_pkg::ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = skeq_pkg::ST_EXEC;
            end
            skeq_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = skeq_pkg::ST_OUT;
            end
            skeq_pkg::ST_OUT: begin
                o_m_tvalid = 1'b1;
                if (i_m_tready) begin
                    n_state = skeq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = skeq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/skeq_dp.sv =====
// Datapath: superkmer store, window extraction, match checks and result registers.
module skeq_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  skeq_pkg::t_cmd                  i_cmd,
    input  logic [skeq_pkg::FUNC_W-1:0]     i_func,
    input  logic [skeq_pkg::KMER_IN_W-1:0]  i_kmer_bits,
    input  logic [skeq_pkg::MPOS_W-1:0]     i_mini_pos,
    input  logic [skeq_pkg::IDX_W-1:0]      i_base_index,
    output logic                            o_ok,
    output logic [skeq_pkg::IDX_W-1:0]      o_position,
    output logic [skeq_pkg::CNT_W-1:0]      o_count
);

    logic [skeq_pkg::STORE_W-1:0]   r_store;
    logic [skeq_pkg::STORE_W-1:0]   n_store;
    logic [skeq_pkg::CNT_W-1:0]     r_cnt;
    logic [skeq_pkg::MPOS_W-1:0]    r_ms;
    logic [skeq_pkg::IDX_W-1:0]     r_base;

    logic [skeq_pkg::FUNC_W-1:0]    r_func;
    logic [skeq_pkg::KMER_IN_W-1:0] r_kmer;
    logic [skeq_pkg::MPOS_W-1:0]    r_mpos;
    logic [skeq_pkg::IDX_W-1:0]     r_bidx;

    logic [skeq_pkg::CNT_W-1:0]     r_first;
    logic                           r_pre_ok;
    logic [skeq_pkg::NEWP_W-1:0]    r_newp;

    logic                           r_ok;
    logic [skeq_pkg::IDX_W-1:0]     r_pos;

    logic [skeq_pkg::NEWP_W-1:0]    newp;
    logic                           ext_pre;
    logic                           qry_pre;
    logic [skeq_pkg::MPOS_W-1:0]    q_off;
    logic [skeq_pkg::CNT_W-1:0]     q_first;
    logic [skeq_pkg::CNT_W-1:0]     n_first;
    logic                           n_pre_ok;

    logic [skeq_pkg::KMER_W-1:0]    kmer_c;
    logic [skeq_pkg::EXT_W-1:0]     ext_vec;
    logic [skeq_pkg::EXT_W-1:0]     ext_shift;
    logic [skeq_pkg::KMER_W-1:0]    window;
    logic                           ovl_match;
    logic                           qry_match;
    logic [skeq_pkg::STORE_W-1:0]   put_mask;
    logic [skeq_pkg::STORE_W-1:0]   put_val;
    logic [skeq_pkg::SHIFT_W-1:0]   put_sh;
    logic [skeq_pkg::EXT_W-1:0]     start_vec;
    logic [skeq_pkg::IDX_W-1:0]     q_pos;

    always_comb begin
        newp    = skeq_pkg::NEWP_W'(skeq_pkg::COMPACTED_LEN) + skeq_pkg::NEWP_W'(r_cnt)
                  - skeq_pkg::NEWP_W'(1);
        ext_pre = (r_cnt != '0) && (r_cnt != '1) && (r_ms != '1)
                  && (r_mpos == r_ms + skeq_pkg::MPOS_W'(1))
                  && (newp < skeq_pkg::NEWP_W'(skeq_pkg::NUC_CAP));
        q_off   = r_ms - r_mpos;
        qry_pre = (r_ms >= r_mpos) && (q_off < r_cnt);
        q_first = r_cnt - q_off - skeq_pkg::CNT_W'(1);
        if (r_func == skeq_pkg::FUNC_EXTEND) begin
            n_first  = r_cnt - skeq_pkg::CNT_W'(1);
            n_pre_ok = ext_pre;
        end else begin
            n_first  = q_first;
            n_pre_ok = qry_pre;
        end
    end

    always_comb begin
        kmer_c    = skeq_pkg::KMER_W'(r_kmer);
        ext_vec   = {r_store, {skeq_pkg::KMER_W{1'b0}}};
        ext_shift = ext_vec << {r_first, 1'b0};
        window    = ext_shift[skeq_pkg::EXT_W-1 -: skeq_pkg::KMER_W];
        ovl_match = (kmer_c[skeq_pkg::KMER_W-1:2] == window[skeq_pkg::OVL_W-1:0]);
        qry_match = (skeq_pkg::KMER_IN_W'(window) == r_kmer);
        put_sh    = {r_newp, 1'b0};
        put_mask  = {2'b11, {(skeq_pkg::STORE_W-2){1'b0}}} >> put_sh;
        put_val   = {kmer_c[1:0], {(skeq_pkg::STORE_W-2){1'b0}}} >> put_sh;
        start_vec = {kmer_c, {skeq_pkg::STORE_W{1'b0}}};
        q_pos     = r_base + skeq_pkg::IDX_W'(r_mpos)
                    - (skeq_pkg::IDX_W'(r_ms) - skeq_pkg::IDX_W'(r_cnt) + skeq_pkg::IDX_W'(1));
        n_store   = start_vec[skeq_pkg::EXT_W-1 -: skeq_pkg::STORE_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_kmer <= i_kmer_bits;
            r_mpos <= i_mini_pos;
            r_bidx <= i_base_index;
        end
        if (i_cmd.prep) begin
            r_first  <= n_first;
            r_pre_ok <= n_pre_ok;
            r_newp   <= newp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store <= '0;
            r_cnt   <= '0;
            r_ms    <= '0;
            r_base  <= '0;
            r_ok    <= 1'b0;
            r_pos   <= '0;
        end else if (i_cmd.exec) begin
            case (r_func)
                skeq_pkg::FUNC_START: begin
                    r_store <= n_store;
                    r_cnt   <= skeq_pkg::CNT_W'(1);
                    r_ms    <= r_mpos;
                    r_base  <= r_bidx;
                    r_ok    <= 1'b1;
                    r_pos   <= '0;
                end
                skeq_pkg::FUNC_EXTEND: begin
                    r_pos <= '0;
                    if (r_pre_ok && ovl_match) begin
                        r_store <= (r_store & ~put_mask) | put_val;
                        r_cnt   <= r_cnt + skeq_pkg::CNT_W'(1);
                        r_ms    <= r_ms + skeq_pkg::MPOS_W'(1);
                        r_ok    <= 1'b1;
                    end else begin
                        r_ok    <= 1'b0;
                    end
                end
                skeq_pkg::FUNC_QUERY: begin
                    if (r_pre_ok && qry_match) begin
                        r_ok  <= 1'b1;
                        r_pos <= q_pos;
                    end else begin
                        r_ok  <= 1'b0;
                        r_pos <= '0;
                    end
                end
                default: begin
                    r_ok  <= 1'b0;
                    r_pos <= '0;
                end
            endcase
        end
    end

    assign o_ok       = r_ok;
    assign o_position = r_pos;
    assign o_count    = r_cnt;

endmodule

// ===== design/superkmer_extend_and_query_core.sv =====
// Top level of the superkmer extend and query core.
// The core holds one superkmer and answers start, extend and query items, one at a time.
// An item is taken in the idle state, then passes through offset and condition setup in the
// prep state and window extraction and compare in the exec state, and its result beat is
// offered in the out state. While a result beat waits, no new item is taken.
module superkmer_extend_and_query_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // Fields from bit 0: kmer_bits[39:0], mini_pos[44:40], base_index[76:45], zero pad.
    input  logic [skeq_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // Fields from bit 0: func[1:0].
    input  logic [skeq_pkg::FUNC_W-1:0]       s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // Fields from bit 0: ok[0], position[32:1], count[37:33], zero pad.
    output logic [skeq_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

    skeq_pkg::t_cmd                 cmd;
    logic                           ok;
    logic [skeq_pkg::IDX_W-1:0]     position;
    logic [skeq_pkg::CNT_W-1:0]     count;

    skeq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (cmd)
    );

    skeq_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_func       (s_axis_tuser),
        .i_kmer_bits  (s_axis_tdata[39:0]),
        .i_mini_pos   (s_axis_tdata[44:40]),
        .i_base_index (s_axis_tdata[76:45]),
        .o_ok         (ok),
        .o_position   (position),
        .o_count      (count)
    );

    assign m_axis_tdata = {2'b00, count, position, ok};

endmodule

// ===== design/skeq_checker.sv =====
// Port-level checker for the superkmer extend and query core, with its bind.
module skeq_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [skeq_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result beat is pending");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> ##3 m_axis_tvalid)
        else $error("result beat not offered three cycles after input beat");

    a_ready_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
        else $error("input not ready after result beat taken");

    a_miss_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[32:1] == '0))
        else $error("position nonzero on a result beat with ok low");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[39:38] == 2'b00))
        else $error("result padding bits not zero");

endmodule

bind superkmer_extend_and_query_core skeq_checker u_skeq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/superkmer_extend_and_query_core_test.sv =====
// Self-checking testbench for the superkmer extend and query core.
module superkmer_extend_and_query_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import skeq_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [CNT_W-1:0]  CNT_SAT     = '1;
    localparam logic [MPOS_W-1:0] MPOS_SAT    = '1;
    localparam int                IDLE_PCT    = 34;
    localparam int                PAD_W       = S_TDATA_W - KMER_IN_W - MPOS_W - IDX_W;

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [KMER_IN_W-1:0] kmer;
        logic [MPOS_W-1:0]    mpos;
        logic [IDX_W-1:0]     bidx;
    } sk_item_t;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] position;
        logic [CNT_W-1:0] count;
    } sk_reply_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // Fields from bit 0: kmer_bits[39:0], mini_pos[44:40], base_index[76:45], zero pad.
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    // Fields from bit 0: func[1:0].
    logic [FUNC_W-1:0]     s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // Fields from bit 0: ok[0], position[32:1], count[37:33], zero pad.
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    logic [STORE_W-1:0]    sk_store = '0;
    logic [CNT_W-1:0]      sk_count = '0;
    logic [MPOS_W-1:0]     sk_mpos  = '0;
    logic [IDX_W-1:0]      sk_base  = '0;

    sk_reply_t             expected_replies[$];
    int                    items_sent = 0;
    int                    errors     = 0;
    bit                    no_idle    = 1'b0;

    superkmer_extend_and_query_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [1:0] nuc_at(int p);
        if (p >= NUC_CAP) begin
            return 2'b00;
        end
        return sk_store[STORE_W-1-2*p -: 2];
    endfunction

    function automatic void nuc_write(int p, logic [1:0] v);
        if (p < NUC_CAP) begin
            sk_store[STORE_W-1-2*p -: 2] = v;
        end
    endfunction

    function automatic logic [KMER_W-1:0] window_at(int first);
        logic [KMER_W-1:0] r;
        r = '0;
        for (int i = 0; i < COMPACTED_LEN; i++) begin
            r = {r[KMER_W-3:0], nuc_at(first + i)};
        end
        return r;
    endfunction

    function automatic sk_reply_t apply_to_superkmer(sk_item_t it);
        sk_reply_t         rep;
        logic [KMER_W-1:0] k;
        logic [KMER_W-1:0] held;
        int                newp;
        int                off;
        rep = '0;
        k = it.kmer[KMER_W-1:0];
        case (it.func)
            FUNC_START: begin
                sk_store = '0;
                for (int i = 0; i < COMPACTED_LEN; i++) begin
                    nuc_write(i, k[2*(COMPACTED_LEN-1-i) +: 2]);
                end
                sk_count = CNT_W'(1);
                sk_mpos  = it.mpos;
                sk_base  = it.bidx;
                rep.ok   = 1'b1;
            end
            FUNC_EXTEND: begin
                newp = COMPACTED_LEN + int'(sk_count) - 1;
                if (sk_count != 0 && sk_count < CNT_SAT && sk_mpos < MPOS_SAT &&
                    int'(it.mpos) == int'(sk_mpos) + 1 && newp < NUC_CAP) begin
                    held = window_at(int'(sk_count) - 1);
                    if (k[KMER_W-1:2] == held[OVL_W-1:0]) begin
                        nuc_write(newp, k[1:0]);
                        sk_count = sk_count + 1'b1;
                        sk_mpos  = sk_mpos + 1'b1;
                        rep.ok   = 1'b1;
                    end
                end
            end
            FUNC_QUERY: begin
                off = int'(sk_mpos) - int'(it.mpos);
                if (off >= 0 && off < int'(sk_count)) begin
                    if (64'(window_at(int'(sk_count) - off - 1)) == 64'(it.kmer)) begin
                        rep.ok       = 1'b1;
                        rep.position = sk_base + 32'(it.mpos)
                                       - (32'(sk_mpos) - 32'(sk_count) + 32'd1);
                    end
                end
            end
            default: ;
        endcase
        rep.count = sk_count;
        return rep;
    endfunction

    function automatic sk_item_t make_item(logic [FUNC_W-1:0] func, logic [KMER_IN_W-1:0] kmer,
                                           logic [MPOS_W-1:0] mpos, logic [IDX_W-1:0] bidx);
        sk_item_t it;
        it.func = func;
        it.kmer = kmer;
        it.mpos = mpos;
        it.bidx = bidx;
        return it;
    endfunction

    function automatic logic [KMER_IN_W-1:0] rand_kmer();
        return KMER_IN_W'({$urandom(), $urandom()});
    endfunction

    function automatic sk_item_t chained_extend();
        logic [KMER_W-1:0] k;
        logic [KMER_W-1:0] held;
        held = window_at(int'(sk_count) - 1);
        k = {held[OVL_W-1:0], 2'($urandom_range(0, 3))};
        return make_item(FUNC_EXTEND, KMER_IN_W'(k), sk_mpos + 1'b1, $urandom());
    endfunction

    function automatic sk_item_t held_query(int off);
        int first;
        if (off > int'(sk_mpos)) begin
            off = int'(sk_mpos);
        end
        first = int'(sk_count) - off - 1;
        return make_item(FUNC_QUERY, KMER_IN_W'(window_at(first)),
                         MPOS_W'(int'(sk_mpos) - off), $urandom());
    endfunction

    task automatic send_item(sk_item_t it);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_W{1'b0}}, it.bidx, it.mpos, it.kmer};
        s_axis_tuser  <= it.func;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        expected_replies.push_back(apply_to_superkmer(it));
        items_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_replies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic test_empty_block();
        send_item(make_item(FUNC_EXTEND, '0, 5'd1, '0));
        send_item(make_item(FUNC_QUERY, '0, '0, '0));
        send_item(make_item(FUNC_UNUSED, '1, '1, '1));
    endtask

    task automatic test_start_extremes();
        send_item(make_item(FUNC_START, '1, MPOS_SAT, '1));
        send_item(make_item(FUNC_EXTEND, '1, '0, '0));
        send_item(held_query(0));
        send_item(make_item(FUNC_START, '0, '0, '0));
        send_item(held_query(0));
        send_item(chained_extend());
        send_item(make_item(FUNC_START, rand_kmer(), 5'd20, $urandom()));
        send_item(make_item(FUNC_QUERY, '1, 5'd20, '0));
    endtask

    task automatic test_extend_and_query();
        sk_item_t it;
        send_item(make_item(FUNC_START, rand_kmer(), 5'd5, '1));
        send_item(chained_extend());
        send_item(chained_extend());
        it = chained_extend();
        it.mpos = it.mpos + 1'b1;
        send_item(it);
        it = chained_extend();
        it.kmer[2 + $urandom_range(0, OVL_W - 1)] ^= 1'b1;
        send_item(it);
        for (int off = 0; off < 3; off++) begin
            send_item(held_query(off));
        end
        send_item(make_item(FUNC_QUERY, '0, sk_mpos - sk_count, '0));
        send_item(make_item(FUNC_QUERY, '0, sk_mpos + 1'b1, '0));
        it = held_query(1);
        it.kmer[0] ^= 1'b1;
        send_item(it);
        send_item(make_item(FUNC_UNUSED, rand_kmer(), 5'($urandom()), $urandom()));
    endtask

    task automatic test_random_runs(int n_items);
        int       stop_at;
        int       steps;
        int       pick;
        sk_item_t it;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            it = make_item(FUNC_START, rand_kmer(),
                           ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                      : 5'($urandom_range(0, 2)),
                           $urandom());
            send_item(it);
            steps = $urandom_range(0, 45);
            for (int s = 0; s < steps && items_sent < stop_at; s++) begin
                pick = $urandom_range(0, 99);
                if (pick < 70 && sk_count != 0) begin
                    it = chained_extend();
                end else if (pick < 80 && sk_count != 0) begin
                    it = held_query($urandom_range(0, int'(sk_count) - 1));
                end else if (pick < 85) begin
                    it = make_item(FUNC_EXTEND, rand_kmer(),
                                   $urandom_range(0, 1) ? sk_mpos + 1'b1 : 5'($urandom()),
                                   $urandom());
                end else if (pick < 90) begin
                    it = make_item(FUNC_QUERY, rand_kmer(), 5'($urandom()), $urandom());
                end else if (pick < 95) begin
                    it = make_item(FUNC_UNUSED, rand_kmer(), 5'($urandom()), $urandom());
                end else begin
                    it = make_item(2'($urandom_range(0, 3)), rand_kmer(), 5'($urandom()),
                                   $urandom());
                end
                send_item(it);
            end
        end
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        test_random_runs(200);
        no_idle = 1'b0;
    endtask

    task automatic test_drain_pause();
        test_random_runs(75);
        wait_drained();
        test_random_runs(75);
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin : check_replies
        sk_reply_t want;
        sk_reply_t got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.ok       = m_axis_tdata[0];
            got.position = m_axis_tdata[32:1];
            got.count    = m_axis_tdata[37:33];
            if (expected_replies.size() == 0) begin
                $error("result beat with no item outstanding");
                errors++;
            end else begin
                want = expected_replies.pop_front();
                if (got.ok !== want.ok) begin
                    $error("ok: expected %0d, actual %0d", want.ok, got.ok);
                    errors++;
                end
                if (got.position !== want.position) begin
                    $error("position: expected %0h, actual %0h", want.position, got.position);
                    errors++;
                end
                if (got.count !== want.count) begin
                    $error("count: expected %0d, actual %0d", want.count, got.count);
                    errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_block();
        test_start_extremes();
        test_extend_and_query();
        test_random_runs(750);
        test_back_to_back();
        test_drain_pause();
        wait_drained();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
